>>> hdl/rgb_to_cmyk_percent_macros.svh
// Assertion macros used by the checker of the RGB to CMYK converter.
`ifndef RGB_TO_CMYK_PERCENT_MACROS_SVH
`define RGB_TO_CMYK_PERCENT_MACROS_SVH

// Overlapping implication on clk_i, disabled while rst_ni is low.
`define RCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_to_cmyk_percent: check failed");

// Non-overlapping implication on clk_i, disabled while rst_ni is low.
`define RCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgb_to_cmyk_percent: check failed");

`endif

>>> hdl/rcp_pkg.sv
// Types, constants and arithmetic helpers of the RGB to CMYK converter.
package rcp_pkg;

  localparam int NumLanes = 3;
  localparam int DivBits  = 7;
  localparam int PipeLat  = 8;

  typedef logic [6:0]  pct_t;
  typedef logic [7:0]  byte_t;
  typedef logic [8:0]  thr_t;
  typedef logic [13:0] num_t;

  localparam pct_t  PctFull   = 7'd100;
  localparam thr_t  ThrReset  = 9'd3;
  localparam byte_t ByteFull  = 8'd255;

  // Divider pipeline payload: one lane each for cyan, magenta and yellow.
  typedef struct packed {
    logic                   vld;
    logic                   blk;
    pct_t                   w;
    pct_t                   k;
    num_t  [NumLanes-1:0]   rem;
    pct_t  [NumLanes-1:0]   quo;
  } div_st_t;

  // Final result as it leaves the back end.
  typedef struct packed {
    logic                   vld;
    pct_t  [NumLanes-1:0]   pct;
    pct_t                   k;
    pct_t  [NumLanes-1:0]   cmy;
    byte_t [NumLanes-1:0]   shade;
    byte_t                  k_shade;
  } res_t;

  // Channel byte to percent: floor(ch*100/255), exact over all byte values.
  function automatic pct_t pct_of_byte(input byte_t ch);
    logic [14:0] x;
    logic [14:0] y;
    logic [14:0] s;
    x = {1'b0, ch, 6'b0} + {2'b0, ch, 5'b0} + {5'b0, ch, 2'b0};
    y = x + 15'd1;
    s = y + {8'b0, y[14:8]};
    return s[14:8];
  endfunction

  // floor(n/100) by reciprocal multiply, exact for n up to 25500.
  function automatic byte_t div100(input logic [14:0] n);
    logic [27:0] p;
    p = {13'b0, n} * 28'd5243;
    return p[26:19];
  endfunction

endpackage

>>> hdl/rcp_front.sv
// Front end: percent scaling, dark test, maximum and divider numerators.
module rcp_front
  import rcp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  byte_t   red_i,
  input  byte_t   green_i,
  input  byte_t   blue_i,
  input  thr_t    thr_i,
  output div_st_t out_o
);

  logic                 s1_vld_q;
  logic                 s1_dark_q;
  pct_t [NumLanes-1:0]  s1_p_q;
  logic                 dark_d;
  pct_t                 w_d;
  pct_t                 d_p;
  div_st_t              s2_d;
  div_st_t              s2_q;

  // All three channels under the threshold force pure black.
  assign dark_d = ({1'b0, red_i} < thr_i) && ({1'b0, green_i} < thr_i) &&
                  ({1'b0, blue_i} < thr_i);

  // Stage 1: valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
    end
  end

  // Stage 1: channel percents and dark flag.
  always_ff @(posedge clk_i) begin
    s1_dark_q <= dark_d;
    s1_p_q[0] <= pct_of_byte(red_i);
    s1_p_q[1] <= pct_of_byte(green_i);
    s1_p_q[2] <= pct_of_byte(blue_i);
  end

  // Stage 2: true maximum, black decision and scaled differences.
  always_comb begin
    w_d = s1_p_q[0];
    if (s1_p_q[1] > w_d) begin
      w_d = s1_p_q[1];
    end
    if (s1_p_q[2] > w_d) begin
      w_d = s1_p_q[2];
    end
    s2_d     = '0;
    s2_d.vld = s1_vld_q;
    s2_d.blk = s1_dark_q || (w_d == '0);
    s2_d.w   = w_d;
    s2_d.k   = PctFull - w_d;
    d_p      = '0;
    for (int l = 0; l < NumLanes; l++) begin
      d_p         = w_d - s1_p_q[l];
      s2_d.rem[l] = {1'b0, d_p, 6'b0} + {2'b0, d_p, 5'b0} + {5'b0, d_p, 2'b0};
    end
  end

  // Stage 2 register; the whole stage clears on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q <= s2_d;
    end
  end

  assign out_o = s2_q;

endmodule

>>> hdl/rcp_div_stage.sv
// One registered slice of the restoring divider, three lanes sharing a divisor.
module rcp_div_stage
  import rcp_pkg::*;
#(
  parameter int unsigned HiBit = DivBits - 1,
  parameter int unsigned Steps = DivBits
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  div_st_t in_i,
  output div_st_t out_o
);

  div_st_t nxt_d;
  div_st_t stg_q;
  num_t    sub_d;

  // Produce quotient bits HiBit down to HiBit-Steps+1 for every lane.
  always_comb begin
    nxt_d = in_i;
    sub_d = '0;
    for (int l = 0; l < NumLanes; l++) begin
      for (int s = 0; s < int'(Steps); s++) begin
        sub_d = num_t'(in_i.w) << (int'(HiBit) - s);
        if (nxt_d.rem[l] >= sub_d) begin
          nxt_d.rem[l] = nxt_d.rem[l] - sub_d;
          nxt_d.quo[l] = nxt_d.quo[l] | (pct_t'(1) << (int'(HiBit) - s));
        end
      end
    end
  end

  // Stage register; the whole stage clears on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= nxt_d;
    end
  end

  assign out_o = stg_q;

endmodule

>>> hdl/rcp_back.sv
// Back end: black override, black folding with cap, and display shades.
module rcp_back
  import rcp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  div_st_t in_i,
  output res_t    res_o
);

  logic                 s6_vld_q;
  pct_t [NumLanes-1:0]  s6_pct_q;
  pct_t                 s6_k_q;
  num_t [NumLanes-1:0]  s6_prod_q;
  pct_t [NumLanes-1:0]  pct_d;
  pct_t                 k_d;
  pct_t                 w_d;

  logic                 s7_vld_q;
  pct_t [NumLanes-1:0]  s7_pct_q;
  pct_t                 s7_k_q;
  pct_t [NumLanes-1:0]  s7_cmy_q;
  pct_t [NumLanes-1:0]  cmy_d;
  logic [8:0]           sum_d;

  res_t                 res_q;
  byte_t [NumLanes-1:0] shade_d;
  logic [14:0]          sc_d;
  logic [14:0]          ksc_d;

  // Stage 6: pure black overrides the quotients; product x*(100-k).
  always_comb begin
    k_d = in_i.blk ? PctFull : in_i.k;
    w_d = in_i.blk ? '0 : in_i.w;
    for (int l = 0; l < NumLanes; l++) begin
      pct_d[l] = in_i.blk ? '0 : in_i.quo[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= in_i.vld;
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_pct_q <= pct_d;
    s6_k_q   <= k_d;
    for (int l = 0; l < NumLanes; l++) begin
      s6_prod_q[l] <= {7'b0, pct_d[l]} * {7'b0, w_d};
    end
  end

  // Stage 7: divide by 100, add black, cap at 100.
  always_comb begin
    sum_d = '0;
    for (int l = 0; l < NumLanes; l++) begin
      sum_d    = {1'b0, div100({1'b0, s6_prod_q[l]})} + {2'b0, s6_k_q};
      cmy_d[l] = (sum_d > {2'b0, PctFull}) ? PctFull : sum_d[6:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s7_pct_q <= s6_pct_q;
    s7_k_q   <= s6_k_q;
    s7_cmy_q <= cmy_d;
  end

  // Stage 8: shade = 255 - v*255/100, with v*255 formed as a shift and subtract.
  always_comb begin
    sc_d = '0;
    for (int l = 0; l < NumLanes; l++) begin
      sc_d       = {s7_cmy_q[l], 8'b0} - {8'b0, s7_cmy_q[l]};
      shade_d[l] = ByteFull - div100(sc_d);
    end
    ksc_d = {s7_k_q, 8'b0} - {8'b0, s7_k_q};
  end

  // Output register; the whole result clears on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q.vld     <= s7_vld_q;
      res_q.pct     <= s7_pct_q;
      res_q.k       <= s7_k_q;
      res_q.cmy     <= s7_cmy_q;
      res_q.shade   <= shade_d;
      res_q.k_shade <= ByteFull - div100(ksc_d);
    end
  end

  assign res_o = res_q;

endmodule

>>> hdl/rgb_to_cmyk_percent.sv
// Top level of the RGB to CMYK percent converter with its register port.
// The result strobe rises once a taken pixel has passed every register stage below.
// Busy never rises.
// Throughput: one pixel per cycle over 8 register stages: percent scaling, numerators,
// the 3-stage restoring divider, the fold multiplier, the fold cap and the shades.
// Reset clears all stage valid bits and sets the dark threshold thr_q to 3.
module rgb_to_cmyk_percent
  import rcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  byte_t       red_i,
  input  byte_t       green_i,
  input  byte_t       blue_i,
  output logic        done_o,
  output pct_t        cyan_pct_o,
  output pct_t        magenta_pct_o,
  output pct_t        yellow_pct_o,
  output pct_t        black_pct_o,
  output pct_t        cyan_cmy_o,
  output pct_t        magenta_cmy_o,
  output pct_t        yellow_cmy_o,
  output byte_t       cyan_shade_o,
  output byte_t       magenta_shade_o,
  output byte_t       yellow_shade_o,
  output byte_t       black_shade_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] AddrThr = 2'd0;

  thr_t    thr_q;
  logic    wr_thr;
  div_st_t front_st;
  div_st_t div_a_st;
  div_st_t div_b_st;
  div_st_t div_c_st;
  res_t    res;

  // Register port: single register, always ready.
  assign pready = 1'b1;
  assign wr_thr = psel && penable && pwrite && pready && (paddr == AddrThr);
  assign prdata = (paddr == AddrThr) ? {23'b0, thr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (wr_thr) begin
      thr_q <= pwdata[8:0];
    end
  end

  // Fully pipelined: every start is a transfer.
  assign busy = 1'b0;

  rcp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start && !busy),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .thr_i   (thr_q),
    .out_o   (front_st)
  );

  // Quotient bits 6..4, 3..2 and 1..0 in three stages.
  rcp_div_stage #(.HiBit(6), .Steps(3)) u_div_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (front_st),
    .out_o  (div_a_st)
  );

  rcp_div_stage #(.HiBit(3), .Steps(2)) u_div_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (div_a_st),
    .out_o  (div_b_st)
  );

  rcp_div_stage #(.HiBit(1), .Steps(2)) u_div_c (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (div_b_st),
    .out_o  (div_c_st)
  );

  rcp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (div_c_st),
    .res_o  (res)
  );

  // Result ports.
  assign done_o          = res.vld;
  assign cyan_pct_o      = res.pct[0];
  assign magenta_pct_o   = res.pct[1];
  assign yellow_pct_o    = res.pct[2];
  assign black_pct_o     = res.k;
  assign cyan_cmy_o      = res.cmy[0];
  assign magenta_cmy_o   = res.cmy[1];
  assign yellow_cmy_o    = res.cmy[2];
  assign cyan_shade_o    = res.shade[0];
  assign magenta_shade_o = res.shade[1];
  assign yellow_shade_o  = res.shade[2];
  assign black_shade_o   = res.k_shade;

endmodule

>>> hdl/rgb_to_cmyk_percent_chk.sv
// Port-level checker for the RGB to CMYK converter and its bind.
`include "rgb_to_cmyk_percent_macros.svh"

module rgb_to_cmyk_percent_chk
  import rcp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input pct_t        cyan_pct_o,
  input pct_t        magenta_pct_o,
  input pct_t        yellow_pct_o,
  input pct_t        black_pct_o,
  input pct_t        cyan_cmy_o,
  input pct_t        magenta_cmy_o,
  input pct_t        yellow_cmy_o,
  input byte_t       cyan_shade_o,
  input byte_t       magenta_shade_o,
  input byte_t       yellow_shade_o,
  input byte_t       black_shade_o
);

  logic pct_ok;
  logic full_black;
  logic black_ok;

  // Percent outputs within full scale.
  assign pct_ok = (cyan_pct_o <= PctFull) && (magenta_pct_o <= PctFull) &&
                  (yellow_pct_o <= PctFull) && (black_pct_o <= PctFull);

  // Full black saturates the folded values and blanks every shade.
  assign full_black = done_o && (black_pct_o == PctFull);
  assign black_ok   = (cyan_cmy_o == PctFull) && (magenta_cmy_o == PctFull) &&
                      (yellow_cmy_o == PctFull) && (cyan_shade_o == '0) &&
                      (magenta_shade_o == '0) && (yellow_shade_o == '0) &&
                      (black_shade_o == '0);

  // Every accepted pixel gives its result after the fixed latency.
  `RCP_ASSERT_NXT(a_latency, start && !busy, ##7 done_o)

  // No result strobe without a pixel accepted one latency earlier.
  `RCP_ASSERT_IMP(a_no_spurious, done_o, $past(start && !busy, 8))

  // Percent outputs never exceed 100.
  `RCP_ASSERT_IMP(a_range, done_o, pct_ok)

  // Full black result.
  `RCP_ASSERT_IMP(a_black, full_black, black_ok)

endmodule

bind rgb_to_cmyk_percent rgb_to_cmyk_percent_chk u_chk (.*);
